### hw/rtl/iidl_pkg.sv
// Shared types, codes and constants for the indexed insert/delete list.
`timescale 1ns / 1ps

package iidl_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W = 32;
  // Wide enough for a position (8 bits) and for a count up to 256.
  localparam int POS_W = 9;
  localparam int LEN_W = 5;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_e_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

### hw/rtl/iidl_cell.sv
// One list slot: holds a value and shifts, loads or holds on each command.
`timescale 1ns / 1ps

module iidl_cell
  import iidl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] prev_value,
  input  logic [DATA_W-1:0] next_value,
  output logic [DATA_W-1:0] value
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_W-1:0] value_next;

  // An insert opens a gap at the target slot by moving everything above it
  // one place up; a delete closes the gap by pulling the upper slots down.
  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (MY_POS == cmd.pos) begin
        value_next = cmd.value;
      end else if (MY_POS > cmd.pos) begin
        value_next = prev_value;
      end
    end else if (cmd.del) begin
      if (MY_POS >= cmd.pos) begin
        value_next = next_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### hw/rtl/indexed_insert_delete_list_top.sv
// Top level of the indexed insert/delete list: chain of cells and control.
`timescale 1ns / 1ps

// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   48    operation[2:0], position[10:3], item_value[42:11]
// m_*      out  40    read_value[31:0], status[33:32], list_length[38:34]
//
// The whole list update happens in the chain of cells at the edge where the
// word is accepted, and the result lands in the output register at the same
// edge, so a new word can follow every cycle while s_tready is high.
// The output register is the only buffer; s_tready drops only while a result
// waits and m_tready is low. Reset (rst, synchronous) empties the list and the
// output register; the cell contents are not cleared, since slots at or above
// the length are never read.

module indexed_insert_delete_list_top
  import iidl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // operation[2:0], position[10:3], item_value[42:11], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_value[31:0], status[33:32], list_length[38:34], zero fill above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  // Input fields.
  logic [2:0]        operation;
  logic [7:0]        position;
  logic [DATA_W-1:0] item_value;

  assign operation  = s_tdata[2:0];
  assign position   = s_tdata[10:3];
  assign item_value = s_tdata[42:11];

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // List length and the chain of cells.
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DATA_W-1:0] cell_value [CAPACITY];
  cell_cmd_t         cmd;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;
    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_prev
      assign prev_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_next
      assign next_v = cell_value[g+1];
    end
    iidl_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_value[g])
    );
  end

  // Operation decode: the position an insert targets, range and full checks.
  logic [POS_W-1:0]  pos_ext;
  logic [POS_W-1:0]  count_ext;
  logic [POS_W-1:0]  ins_pos;
  logic              want_ins;
  logic              do_del;
  logic [DATA_W-1:0] rd_value;
  status_e_t         status;
  logic [POS_W-1:0]  len_ext;

  assign pos_ext   = POS_W'(position);
  assign count_ext = POS_W'(count);

  always_comb begin
    ins_pos  = '0;
    want_ins = 1'b0;
    do_del   = 1'b0;
    rd_value = MISS_VALUE;
    status   = ST_DONE;
    unique case (operation)
      OP_READ: begin
        if (pos_ext < count_ext) begin
          rd_value = cell_value[pos_ext[IW-1:0]];
        end else begin
          status = ST_RANGE;
        end
      end
      OP_HEAD: begin
        want_ins = 1'b1;
        ins_pos  = '0;
      end
      OP_TAIL: begin
        want_ins = 1'b1;
        ins_pos  = count_ext;
      end
      OP_INSERT: begin
        want_ins = 1'b1;
        ins_pos  = pos_ext;
      end
      OP_DELETE: begin
        if (pos_ext < count_ext) begin
          do_del = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
    // The range check on an insert takes priority over the full check.
    if (want_ins) begin
      if (ins_pos > count_ext) begin
        status   = ST_RANGE;
        want_ins = 1'b0;
      end else if (count_ext >= CAP_POS) begin
        status   = ST_FULL;
        want_ins = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.ins   = accept && want_ins;
    cmd.del   = accept && do_del;
    cmd.pos   = want_ins ? ins_pos : pos_ext;
    cmd.value = item_value;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.del) begin
      count_next = count - CW'(1);
    end
  end

  // The reported length is the new count, kept to the field's 5 bits.
  assign len_ext = POS_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, len_ext[LEN_W-1:0], status, rd_value};
    end
  end

endmodule

### hw/rtl/iidl_checker.sv
// Port-level checks for the indexed insert/delete list, bound to the top.
`timescale 1ns / 1ps

module iidl_checker
  import iidl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present right after reset");

  // A waiting result holds its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // A full status reports a length equal to the capacity.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == ST_FULL |-> m_tdata[38:34] == CAP_LEN)
    else $error("full status with a length other than capacity");

  // A failed operation carries the miss marker as its value.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != ST_DONE |-> m_tdata[31:0] == MISS_VALUE)
    else $error("failed operation returned a value");

  // A command word that is not taken stays on the bus unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("stalled command word changed");

endmodule

bind indexed_insert_delete_list_top iidl_checker #(
  .CAPACITY(CAPACITY)
) u_iidl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
